// ===== design/b2r_pkg.sv =====
// shared types, microcode opcodes and numeral pattern tables for the roman numeral emitter
// no dependencies
package b2r_pkg;

  // microcode operations
  typedef enum logic [2:0] {
    OP_LOADM,
    OP_EMITM,
    OP_LOADD,
    OP_EMITD,
    OP_FINISH
  } op_t;

  // digit places
  localparam logic [1:0] PL_HUND = 2'd0;
  localparam logic [1:0] PL_TENS = 2'd1;
  localparam logic [1:0] PL_ONES = 2'd2;

  // symbol roles inside one digit pattern
  typedef enum logic [1:0] {
    SYM_UNIT,
    SYM_FIVE,
    SYM_TEN
  } sym_t;

  localparam logic [7:0] CHAR_M = 8'h4d;

  typedef struct packed {
    op_t        op;
    logic [1:0] place;
    logic [3:0] target;
  } ucw_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] place;
    logic       active;
  } ctrl_t;

  typedef struct packed {
    logic loop_done;
  } stat_t;

  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:                n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
      4'd3, 4'd7:                n = 3'd3;
      4'd8:                      n = 3'd4;
      default:                   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t pat_sym(input logic [3:0] d, input logic [1:0] i);
    sym_t s;
    unique case (d)
      4'd4:                s = (i == 2'd0) ? SYM_UNIT : SYM_FIVE;
      4'd5:                s = SYM_FIVE;
      4'd6, 4'd7, 4'd8:    s = (i == 2'd0) ? SYM_FIVE : SYM_UNIT;
      4'd9:                s = (i == 2'd0) ? SYM_UNIT : SYM_TEN;
      default:             s = SYM_UNIT;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] letter(input logic [1:0] place, input sym_t s);
    logic [7:0] c;
    unique case (place)
      PL_HUND: c = (s == SYM_UNIT) ? 8'h43 : (s == SYM_FIVE) ? 8'h44 : 8'h4d; // C D M
      PL_TENS: c = (s == SYM_UNIT) ? 8'h58 : (s == SYM_FIVE) ? 8'h4c : 8'h43; // X L C
      PL_ONES: c = (s == SYM_UNIT) ? 8'h49 : (s == SYM_FIVE) ? 8'h56 : 8'h58; // I V X
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/binary_to_roman_numeral.sv =====
// top level of the roman numeral emitter: splitter, microcode sequencer and datapath
// uses b2r_pkg, b2r_split, b2r_ucode, b2r_datapath
//
// channel   handshake          payload
// input     start / busy       value[11:0]
// result    strobe             symbol[7:0], last, bad_value, empty_res
//
// a value is taken when start is high and busy is low; busy then stays high
// while the program runs: a load step and an emit step per digit place, the emit
// step repeating for each symbol of that place, then a finish step.
// each result word shows for exactly one cycle with strobe high; the receiver cannot stall.
// rst is synchronous and clears the step counter, busy and strobe.
module binary_to_roman_numeral
  import b2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] value,
  output logic        strobe,
  output logic [7:0]  symbol,
  output logic        last,
  output logic        bad_value,
  output logic        empty_res
);

  logic       load;
  logic [2:0] th;
  logic [3:0] hu, te, on;
  ctrl_t      ctrl;
  stat_t      stat;

  assign load = start && !busy;

  b2r_split u_split (
    .value (value),
    .th    (th),
    .hu    (hu),
    .te    (te),
    .on    (on)
  );

  b2r_ucode u_ucode (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  b2r_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .th_in     (th),
    .hu_in     (hu),
    .te_in     (te),
    .on_in     (on),
    .ctrl      (ctrl),
    .stat      (stat),
    .strobe    (strobe),
    .symbol    (symbol),
    .last      (last),
    .bad_value (bad_value),
    .empty_res (empty_res)
  );

endmodule

// ===== design/b2r_split.sv =====
// decimal digit splitter: thousands, hundreds, tens and ones of a 12-bit value
// uses b2r_pkg
module b2r_split
  import b2r_pkg::*;
(
  input  logic [11:0] value,
  output logic [2:0]  th,
  output logic [3:0]  hu,
  output logic [3:0]  te,
  output logic [3:0]  on
);

  logic [11:0] base1;
  logic [9:0]  rem1;
  logic [9:0]  base2;
  logic [6:0]  rem2;
  logic [6:0]  base3;

  // each digit is a set of independent threshold compares
  always_comb begin
    th    = 3'd0;
    base1 = 12'd0;
    for (int k = 1; k <= 4; k++) begin
      if (value >= 12'(k * 1000)) begin
        th    = 3'(k);
        base1 = 12'(k * 1000);
      end
    end
    rem1 = 10'(value - base1);

    hu    = 4'd0;
    base2 = 10'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem1 >= 10'(k * 100)) begin
        hu    = 4'(k);
        base2 = 10'(k * 100);
      end
    end
    rem2 = 7'(rem1 - base2);

    te    = 4'd0;
    base3 = 7'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem2 >= 7'(k * 10)) begin
        te    = 4'(k);
        base3 = 7'(k * 10);
      end
    end
    on = 4'(rem2 - base3);
  end

endmodule

// ===== design/b2r_ucode.sv =====
// microcode sequencer: program rom, step counter, busy flag and conditional jumps
// uses b2r_pkg
module b2r_ucode
  import b2r_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  localparam int ProgLen = 9;

  localparam ucw_t PROG [ProgLen] = '{
    '{op: OP_LOADM,  place: PL_HUND, target: 4'd1},
    '{op: OP_EMITM,  place: PL_HUND, target: 4'd2},
    '{op: OP_LOADD,  place: PL_HUND, target: 4'd3},
    '{op: OP_EMITD,  place: PL_HUND, target: 4'd4},
    '{op: OP_LOADD,  place: PL_TENS, target: 4'd5},
    '{op: OP_EMITD,  place: PL_TENS, target: 4'd6},
    '{op: OP_LOADD,  place: PL_ONES, target: 4'd7},
    '{op: OP_EMITD,  place: PL_ONES, target: 4'd8},
    '{op: OP_FINISH, place: PL_HUND, target: 4'd0}
  };

  logic [3:0] pc, pc_next;
  logic       busy_next;
  ucw_t       word;

  assign word        = PROG[pc];
  assign ctrl.op     = word.op;
  assign ctrl.place  = word.place;
  assign ctrl.active = busy;

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (busy) begin
      priority case (word.op)
        OP_FINISH: busy_next = 1'b0;
        // emit steps loop on themselves until the datapath reports the run is out
        OP_EMITM, OP_EMITD: if (stat.loop_done) pc_next = word.target;
        default: pc_next = word.target;
      endcase
    end else if (load) begin
      pc_next   = 4'd0;
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 4'd0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

// ===== design/b2r_datapath.sv =====
// datapath: digit registers, symbol counters and the registered result word
// uses b2r_pkg
module b2r_datapath
  import b2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [2:0] th_in,
  input  logic [3:0] hu_in,
  input  logic [3:0] te_in,
  input  logic [3:0] on_in,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  output logic       strobe,
  output logic [7:0] symbol,
  output logic       last,
  output logic       bad_value,
  output logic       empty_res
);

  logic [1:0] mcnt;
  logic [1:0] th_m;
  logic [3:0] hu, te, on;
  logic       bad;
  logic [3:0] remain;
  logic       nonempty;
  logic [3:0] dig;
  logic [1:0] place;
  logic [2:0] idx;
  logic [3:0] total;
  logic [3:0] dig_sel;
  logic       idx_end;
  logic       mcnt_zero;

  assign total = 4'(th_m) + 4'(pat_len(hu)) + 4'(pat_len(te)) + 4'(pat_len(on));
  assign idx_end   = (idx == pat_len(dig));
  assign mcnt_zero = (mcnt == 2'd0);
  assign stat.loop_done = (ctrl.op == OP_EMITM) ? mcnt_zero : idx_end;

  always_comb begin
    unique case (ctrl.place)
      PL_HUND: dig_sel = hu;
      PL_TENS: dig_sel = te;
      default: dig_sel = on;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bad  <= (th_in == 3'd0) || (th_in > 3'd3);
      th_m <= ((th_in == 3'd0) || (th_in > 3'd3)) ? 2'd0 : th_in[1:0];
      hu   <= hu_in;
      te   <= te_in;
      on   <= on_in;
    end
    if (ctrl.active) begin
      unique case (ctrl.op)
        OP_LOADM: begin
          mcnt     <= th_m;
          remain   <= total;
          nonempty <= (total != 4'd0);
        end
        OP_EMITM: if (!mcnt_zero) begin
          mcnt   <= mcnt - 2'd1;
          remain <= remain - 4'd1;
        end
        OP_LOADD: begin
          dig   <= dig_sel;
          place <= ctrl.place;
          idx   <= 3'd0;
        end
        OP_EMITD: if (!idx_end) begin
          idx    <= idx + 3'd1;
          remain <= remain - 4'd1;
        end
        default: ;
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ctrl.active) begin
        unique case (ctrl.op)
          OP_EMITM:  strobe <= !mcnt_zero;
          OP_EMITD:  strobe <= !idx_end;
          OP_FINISH: strobe <= !nonempty;
          default:   strobe <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      unique case (ctrl.op)
        OP_EMITM: begin
          symbol    <= CHAR_M;
          last      <= (remain == 4'd1);
          bad_value <= bad;
          empty_res <= 1'b0;
        end
        OP_EMITD: begin
          symbol    <= letter(place, pat_sym(dig, idx[1:0]));
          last      <= (remain == 4'd1);
          bad_value <= bad;
          empty_res <= 1'b0;
        end
        OP_FINISH: begin
          symbol    <= 8'h00;
          last      <= 1'b1;
          bad_value <= bad;
          empty_res <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/tb_binary_to_roman_numeral.sv =====
// testbench for binary_to_roman_numeral: drives values, predicts the numeral words, checks results
// depends on b2r_pkg and the binary_to_roman_numeral rtl
module tb_binary_to_roman_numeral;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 355;
  localparam int unsigned REPORT_MAX = 10;

  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_L = 8'h4c;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_M = 8'h4d;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       bad_value;
    logic       empty_res;
  } numeral_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [11:0] value = '0;
  logic        busy;
  logic        strobe;
  logic [7:0]  symbol;
  logic        last;
  logic        bad_value;
  logic        empty_res;

  logic [11:0]   values_to_send[$];
  numeral_word_t numeral_words[$];
  int unsigned   failures = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;

  binary_to_roman_numeral u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .symbol    (symbol),
    .last      (last),
    .bad_value (bad_value),
    .empty_res (empty_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // appends the words the block should emit for one value
  function automatic void predict_numeral(input logic [11:0] v);
    logic [7:0]    chars[15];
    logic [7:0]    unit_ch, five_ch, ten_ch;
    int unsigned   n, th, rem, d, k, p;
    int unsigned   digits[3];
    logic          bad;
    numeral_word_t w;
    n = 0;
    th = v / 1000;
    rem = v % 1000;
    digits[0] = rem / 100;
    digits[1] = (rem % 100) / 10;
    digits[2] = rem % 10;
    bad = (th < 1) || (th > 3);
    if (!bad) begin
      for (k = 0; k < th; k++) begin
        chars[n] = CH_M;
        n = n + 1;
      end
    end
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin unit_ch = CH_C; five_ch = CH_D; ten_ch = CH_M; end
        1: begin unit_ch = CH_X; five_ch = CH_L; ten_ch = CH_C; end
        default: begin unit_ch = CH_I; five_ch = CH_V; ten_ch = CH_X; end
      endcase
      d = digits[p];
      if (d == 9) begin
        chars[n] = unit_ch;
        chars[n + 1] = ten_ch;
        n = n + 2;
      end else if (d == 4) begin
        chars[n] = unit_ch;
        chars[n + 1] = five_ch;
        n = n + 2;
      end else begin
        if (d >= 5) begin
          chars[n] = five_ch;
          n = n + 1;
        end
        for (k = 0; k < d % 5; k++) begin
          chars[n] = unit_ch;
          n = n + 1;
        end
      end
    end
    if (n == 0) begin
      w.symbol = 8'h00;
      w.last = 1'b1;
      w.bad_value = bad;
      w.empty_res = 1'b1;
      numeral_words.push_back(w);
    end else begin
      for (k = 0; k < n; k++) begin
        w.symbol = chars[k];
        w.last = (k + 1 == n);
        w.bad_value = bad;
        w.empty_res = 1'b0;
        numeral_words.push_back(w);
      end
    end
  endfunction

  // driver: bursts of values with random gaps, gaps counted regardless of busy
  always @(posedge clk) begin
    logic        start_n;
    logic [11:0] value_n;
    logic        taken;
    taken = start && !busy && !rst;
    start_n = 1'b0;
    value_n = 12'($urandom);
    if (taken) begin
      predict_numeral(value);
    end
    if (rst) begin
      start_n = 1'b0;
    end else if (start && !taken) begin
      start_n = 1'b1;
      value_n = value;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
    end else if (values_to_send.size() > 0) begin
      start_n = 1'b1;
      value_n = values_to_send.pop_front();
      if (burst_left > 0) begin
        burst_left = burst_left - 1;
      end else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
    end
    start <= start_n;
    value <= value_n;
  end

  // monitor: every strobed word must match the oldest expected word
  always @(posedge clk) begin
    numeral_word_t got, want;
    if (!rst && strobe) begin
      got.symbol = symbol;
      got.last = last;
      got.bad_value = bad_value;
      got.empty_res = empty_res;
      if (numeral_words.size() == 0) begin
        failures = failures + 1;
        if (failures <= REPORT_MAX)
          $display("unexpected word: symbol=%h last=%b bad=%b empty=%b",
                   symbol, last, bad_value, empty_res);
      end else begin
        want = numeral_words.pop_front();
        if (got !== want) begin
          failures = failures + 1;
          if (failures <= REPORT_MAX)
            $display({"mismatch: expected symbol=%h last=%b bad=%b empty=%b,",
                      " got symbol=%h last=%b bad=%b empty=%b"},
                     want.symbol, want.last, want.bad_value, want.empty_res,
                     got.symbol, got.last, got.bad_value, got.empty_res);
        end
      end
    end
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i, pick;
    logic [11:0] v;
    // directed: empty numerals, bad thousands, longest run, subtractive pairs
    values_to_send.push_back(12'd0);
    values_to_send.push_back(12'd4000);
    values_to_send.push_back(12'd4095);
    values_to_send.push_back(12'd1000);
    values_to_send.push_back(12'd3999);
    values_to_send.push_back(12'd3888);
    values_to_send.push_back(12'd999);
    values_to_send.push_back(12'd1);
    values_to_send.push_back(12'd4);
    values_to_send.push_back(12'd5);
    values_to_send.push_back(12'd9);
    values_to_send.push_back(12'd40);
    values_to_send.push_back(12'd90);
    values_to_send.push_back(12'd400);
    values_to_send.push_back(12'd900);
    values_to_send.push_back(12'd1994);
    values_to_send.push_back(12'd2444);
    values_to_send.push_back(12'd3494);
    values_to_send.push_back(12'd1111);
    values_to_send.push_back(12'd2222);
    values_to_send.push_back(12'd3000);
    values_to_send.push_back(12'd4001);
    values_to_send.push_back(12'd4049);
    values_to_send.push_back(12'd500);
    values_to_send.push_back(12'd2048);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        v = 12'($urandom_range(1000, 3999));
      else if (pick == 7)
        v = 12'($urandom_range(0, 999));
      else if (pick == 8)
        v = 12'($urandom_range(4000, 4095));
      else
        v = 12'($urandom);
      values_to_send.push_back(v);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // sample away from the driving edge so queue and start are settled
    while (values_to_send.size() > 0 || start) @(negedge clk);
    while (numeral_words.size() > 0) @(negedge clk);
    repeat (40) @(posedge clk);

    if (failures == 0 && numeral_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
